// ===== hdl/sct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Types, codes and the phoneme duration calculation for the speech chip
// register and timer block.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned RemainW  = 19;
  localparam int unsigned TickW    = 12;
  localparam int unsigned TblDepth = 64;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [2:0] REG_DUR_PHON  = 3'd0;
  localparam logic [2:0] REG_INFL      = 3'd1;
  localparam logic [2:0] REG_RATE_INFL = 3'd2;
  localparam logic [2:0] REG_CTRL_AMP  = 3'd3;
  localparam logic [2:0] REG_FILTER    = 3'd4;

  localparam logic [7:0] CTRL_RESET  = 8'h80;
  localparam logic [7:0] STATUS_REQ  = 8'h80;
  localparam logic [RemainW-1:0] RemainMax = '1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [2:0]       reg_index;
    logic [7:0]       wdata;
    logic [TickW-1:0] tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_edge;
    logic       request_cleared;
    logic       phoneme_start;
    logic [5:0] phoneme_code;
  } out_item_t;

  // idx = {rate[3:0], dur[1:0]}; evaluated at elaboration only
  function automatic logic [RemainW-1:0] phoneme_cycles(input longint unsigned clock_hz,
                                                        input longint unsigned idx);
    longint unsigned rate;
    longint unsigned dur;
    longint unsigned ms;
    longint unsigned cyc;
    rate = (idx >> 2) & 64'd15;
    dur  = idx & 64'd3;
    ms   = ((64'd16 - rate) * 64'd4096 / 64'd1023) * (64'd4 - dur);
    cyc  = ms * clock_hz / 64'd1000;
    if (cyc > 64'(RemainMax)) begin
      cyc = 64'(RemainMax);
    end
    return cyc[RemainW-1:0];
  endfunction

endpackage

// ===== hdl/sct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_if
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface sct_in_if;
  logic              valid;
  logic              ready;
  sct_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sct_out_if;
  logic               valid;
  logic               ready;
  sct_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/speech_chip_register_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_chip_register_timer
// Register file and phoneme countdown of a phoneme speech chip. One result
// transaction per command transaction.
// ----------------------------------------------------------------------------
// Result is registered: valid in the cycle after the command is accepted.
// Throughput: 1 transaction per cycle; one result register holds the output,
//   and a new command is taken whenever it is empty or being drained.
// Phoneme durations come from a 64-entry constant table built from CLOCK_HZ.
// Reset: all registers zero except control/amplitude (0x80, powered down);
//   no result pending.
module speech_chip_register_timer #(
  parameter int unsigned CLOCK_HZ = 1022727
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_in_if.sink    in_i,
  sct_out_if.source out_o
);

  localparam int unsigned RW = sct_pkg::RemainW;

  logic [RW-1:0] cyc_tbl [sct_pkg::TblDepth];

  for (genvar g = 0; g < sct_pkg::TblDepth; g++) begin : g_tbl
    localparam logic [RW-1:0] Cyc = sct_pkg::phoneme_cycles(64'(CLOCK_HZ), 64'(g));
    assign cyc_tbl[g] = Cyc;
  end

  logic [7:0]    dur_q, dur_d;
  logic [7:0]    infl_q, infl_d;
  logic [7:0]    rate_q, rate_d;
  logic [7:0]    ctrl_q, ctrl_d;
  logic [7:0]    filt_q, filt_d;
  logic [RW-1:0] rem_q, rem_d;
  logic          flag_q, flag_d;

  logic               out_valid_q;
  sct_pkg::out_item_t out_data_q, res;
  logic               accept;
  logic [5:0]         tbl_idx;
  logic [RW-1:0]      reload;
  sct_pkg::in_item_t  cmd;

  assign cmd          = in_i.data;
  assign in_i.ready   = !out_valid_q || out_o.ready;
  assign accept       = in_i.valid && in_i.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_data_q;

  assign tbl_idx = (cmd.reg_index == sct_pkg::REG_DUR_PHON) ? {rate_q[7:4], cmd.wdata[7:6]}
                                                             : {rate_q[7:4], dur_q[7:6]};
  assign reload  = cyc_tbl[tbl_idx];

  always_comb begin
    dur_d  = dur_q;
    infl_d = infl_q;
    rate_d = rate_q;
    ctrl_d = ctrl_q;
    filt_d = filt_q;
    rem_d  = rem_q;
    flag_d = flag_q;
    res    = '0;
    unique case (cmd.mode)
      sct_pkg::MODE_WRITE: begin
        if (cmd.reg_index <= sct_pkg::REG_RATE_INFL) begin
          res.request_cleared = flag_q;
          flag_d              = 1'b0;
        end
        case (cmd.reg_index)
          sct_pkg::REG_DUR_PHON: begin
            dur_d = cmd.wdata;
            if (!ctrl_q[7]) begin
              rem_d             = reload;
              res.phoneme_start = 1'b1;
            end
          end
          sct_pkg::REG_INFL:      infl_d = cmd.wdata;
          sct_pkg::REG_RATE_INFL: rate_d = cmd.wdata;
          sct_pkg::REG_CTRL_AMP: begin
            ctrl_d = cmd.wdata;
            if (ctrl_q[7] && !cmd.wdata[7]) begin
              rem_d             = reload;
              res.phoneme_start = 1'b1;
            end
            if (!ctrl_q[7] && cmd.wdata[7]) begin
              res.request_cleared = flag_q;
              flag_d              = 1'b0;
              rem_d               = '0;
            end
          end
          sct_pkg::REG_FILTER: filt_d = cmd.wdata;
          default: ;
        endcase
      end
      sct_pkg::MODE_READ: begin
        res.rdata = flag_q ? sct_pkg::STATUS_REQ : 8'h00;
      end
      sct_pkg::MODE_TICK: begin
        if ((cmd.tick_cycles != '0) && (rem_q != '0) && !ctrl_q[7]) begin
          if (RW'(cmd.tick_cycles) < rem_q) begin
            rem_d = rem_q - RW'(cmd.tick_cycles);
          end else begin
            rem_d = '0;
            if (!flag_q) begin
              flag_d       = 1'b1;
              res.irq_edge = (dur_q[7:6] != 2'b00);
            end
          end
        end
      end
      default: ;
    endcase
    res.phoneme_code = dur_d[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q       <= '0;
      infl_q      <= '0;
      rate_q      <= '0;
      ctrl_q      <= sct_pkg::CTRL_RESET;
      filt_q      <= '0;
      rem_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        dur_q  <= dur_d;
        infl_q <= infl_d;
        rate_q <= rate_d;
        ctrl_q <= ctrl_d;
        filt_q <= filt_d;
        rem_q  <= rem_d;
        flag_q <= flag_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  // powered down: no pending request, countdown stopped
  a_down_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q[7] |-> !flag_q)
    else $error("request flag set while powered down");

  a_down_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q[7] |-> (rem_q == '0))
    else $error("countdown running while powered down");

  a_irq_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.irq_edge &&
                      (out_data_q.phoneme_start || out_data_q.request_cleared ||
                       (out_data_q.rdata != 8'h00))))
    else $error("interrupt edge combined with write or read result");

  a_irq_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.irq_edge) |=> flag_q)
    else $error("interrupt edge without request flag");

endmodule

// ===== verif/sct_timer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_timer_checker
// Watches the command and result channels of the speech chip register and
// timer block. It keeps its own copy of the register file, countdown and
// request flag, predicts one status word per accepted command, and compares
// each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module sct_timer_checker #(
  parameter int unsigned CLOCK_HZ = 1022727
) (
  input  logic clk_i,
  input  logic rst_ni,
  sct_in_if    cmd_if,
  sct_out_if   rsp_if,
  output int   errors_o,
  output int   pending_o
);

  localparam int unsigned RemainW = sct_pkg::RemainW;

  logic [7:0]         dur_phon_q;
  logic [7:0]         infl_q;
  logic [7:0]         rate_infl_q;
  logic [7:0]         ctrl_amp_q;
  logic [7:0]         filter_q;
  logic [RemainW-1:0] remain_q;
  logic               req_q;
  sct_pkg::out_item_t expected_status_q[$];
  sct_pkg::out_item_t want;
  sct_pkg::out_item_t got;
  int                 errors;

  function automatic logic [RemainW-1:0] countdown_len(input logic [3:0] rate,
                                                       input logic [1:0] dur);
    longint unsigned r;
    longint unsigned d;
    longint unsigned ms;
    longint unsigned cyc;
    r   = rate;
    d   = dur;
    ms  = ((64'd16 - r) * 64'd4096 / 64'd1023) * (64'd4 - d);
    cyc = ms * CLOCK_HZ / 64'd1000;
    if (cyc > (64'd1 << RemainW) - 64'd1) begin
      cyc = (64'd1 << RemainW) - 64'd1;
    end
    return cyc[RemainW-1:0];
  endfunction

  task automatic apply_command(input sct_pkg::in_item_t c, output sct_pkg::out_item_t r);
    logic was_down;
    r = '0;
    case (c.mode)
      sct_pkg::MODE_WRITE: begin
        if (c.reg_index <= sct_pkg::REG_RATE_INFL) begin
          r.request_cleared = req_q;
          req_q = 1'b0;
        end
        case (c.reg_index)
          sct_pkg::REG_DUR_PHON: begin
            dur_phon_q = c.wdata;
            if (!ctrl_amp_q[7]) begin
              remain_q = countdown_len(rate_infl_q[7:4], dur_phon_q[7:6]);
              r.phoneme_start = 1'b1;
            end
          end
          sct_pkg::REG_INFL:      infl_q = c.wdata;
          sct_pkg::REG_RATE_INFL: rate_infl_q = c.wdata;
          sct_pkg::REG_CTRL_AMP: begin
            was_down   = ctrl_amp_q[7];
            ctrl_amp_q = c.wdata;
            if (was_down && !ctrl_amp_q[7]) begin
              remain_q = countdown_len(rate_infl_q[7:4], dur_phon_q[7:6]);
              r.phoneme_start = 1'b1;
            end
            if (!was_down && ctrl_amp_q[7]) begin
              if (req_q) begin
                r.request_cleared = 1'b1;
              end
              req_q    = 1'b0;
              remain_q = '0;
            end
          end
          sct_pkg::REG_FILTER: filter_q = c.wdata;
          default: ;
        endcase
      end
      sct_pkg::MODE_READ: r.rdata = req_q ? sct_pkg::STATUS_REQ : 8'h00;
      sct_pkg::MODE_TICK: begin
        if (c.tick_cycles != '0 && remain_q != '0 && !ctrl_amp_q[7]) begin
          if (RemainW'(c.tick_cycles) < remain_q) begin
            remain_q = remain_q - RemainW'(c.tick_cycles);
          end else begin
            remain_q = '0;
            if (!req_q) begin
              req_q      = 1'b1;
              r.irq_edge = (dur_phon_q[7:6] != 2'b00);
            end
          end
        end
      end
      default: ;
    endcase
    r.phoneme_code = dur_phon_q[5:0];
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_phon_q  = 8'h00;
      infl_q      = 8'h00;
      rate_infl_q = 8'h00;
      ctrl_amp_q  = sct_pkg::CTRL_RESET;
      filter_q    = 8'h00;
      remain_q    = '0;
      req_q       = 1'b0;
      expected_status_q.delete();
      errors      = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_status_q.size() == 0) begin
          $error("result transaction with no command outstanding: 0x%0h", got);
          errors++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("rdata", 32'(want.rdata), 32'(got.rdata));
          check_field("irq_edge", 32'(want.irq_edge), 32'(got.irq_edge));
          check_field("request_cleared", 32'(want.request_cleared),
                      32'(got.request_cleared));
          check_field("phoneme_start", 32'(want.phoneme_start), 32'(got.phoneme_start));
          check_field("phoneme_code", 32'(want.phoneme_code), 32'(got.phoneme_code));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        apply_command(cmd_if.data, want);
        expected_status_q.push_back(want);
      end
      errors_o  <= errors;
      pending_o <= expected_status_q.size();
    end
  end

endmodule

// ===== verif/tb_speech_chip_register_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_speech_chip_register_timer
// Drives command transactions into the speech chip register and timer block:
// a directed run through power-up, countdown, completion, acknowledge and
// power-down, then random phases of writes, reads and ticks with bursty
// sending and a stalling receiver. The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_speech_chip_register_timer;

  localparam int unsigned ClockHz      = 1022727;
  localparam int unsigned TickW        = sct_pkg::TickW;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int          PhaseItems   = 360;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   errors;
  int   pending;
  int   burst_left;
  bit   gaps_on;
  bit   stall_on;
  logic [15:0] stall_pat;
  int   stall_idx;

  sct_in_if  cmd_if ();
  sct_out_if rsp_if ();

  speech_chip_register_timer #(.CLOCK_HZ(ClockHz)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  sct_timer_checker #(.CLOCK_HZ(ClockHz)) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_if   (cmd_if),
    .rsp_if   (rsp_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (stall_idx == 0) begin
      stall_pat = 16'($urandom()) | 16'h0001;
    end
    rsp_if.ready <= !stall_on || stall_pat[stall_idx[3:0]];
    stall_idx = (stall_idx + 1) % 64;
  end

  function automatic sct_pkg::in_item_t mk(input logic [1:0] mode, input logic [2:0] idx,
                                           input logic [7:0] wdata,
                                           input logic [TickW-1:0] ticks);
    sct_pkg::in_item_t c;
    c.mode        = mode;
    c.reg_index   = idx;
    c.wdata       = wdata;
    c.tick_cycles = ticks;
    return c;
  endfunction

  function automatic sct_pkg::in_item_t random_cmd();
    sct_pkg::in_item_t c;
    int unsigned       pick;
    int unsigned       sub;
    c.mode        = sct_pkg::MODE_WRITE;
    c.reg_index   = 3'($urandom_range(0, 7));
    c.wdata       = 8'($urandom_range(0, 255));
    c.tick_cycles = TickW'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (pick < 42) begin
      c.mode = sct_pkg::MODE_TICK;
      if (sub < 8) begin
        c.tick_cycles = '0;
      end else if (sub >= 30) begin
        c.tick_cycles = TickW'($urandom_range(2048, 4095));
      end
    end else if (pick < 56) begin
      c.mode = sct_pkg::MODE_READ;
    end else if (pick < 60) begin
      c.mode = MODE_UNUSED;
    end else if (sub < 30) begin
      c.reg_index = sct_pkg::REG_DUR_PHON;
    end else if (sub < 45) begin
      c.reg_index = sct_pkg::REG_RATE_INFL;
      if ($urandom_range(0, 99) >= 15) begin
        c.wdata[7:4] = 4'($urandom_range(10, 15));
      end
    end else if (sub < 62) begin
      c.reg_index = sct_pkg::REG_CTRL_AMP;
      c.wdata[7]  = ($urandom_range(0, 99) < 20);
    end else if (sub < 72) begin
      c.reg_index = sct_pkg::REG_INFL;
    end else if (sub < 82) begin
      c.reg_index = sct_pkg::REG_FILTER;
    end else begin
      c.reg_index = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  task automatic send_cmd(input sct_pkg::in_item_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk_i); while (!cmd_if.ready);
    @(negedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rsp_if.ready = 1'b0;
    stall_pat    = 16'hffff;
    stall_idx    = 1;
    burst_left   = 0;
    gaps_on      = 1'b0;
    stall_on     = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_cmd(mk(sct_pkg::MODE_READ, sct_pkg::REG_DUR_PHON, 8'h00, 12'd0));
    send_cmd(mk(sct_pkg::MODE_TICK, sct_pkg::REG_DUR_PHON, 8'h00, 12'd4095));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_DUR_PHON, 8'hff, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_CTRL_AMP, 8'h00, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_RATE_INFL, 8'hff, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_DUR_PHON, 8'hc5, 12'd0));
    send_cmd(mk(sct_pkg::MODE_TICK, sct_pkg::REG_DUR_PHON, 8'h00, 12'd0));
    send_cmd(mk(sct_pkg::MODE_TICK, 3'd7, 8'hff, 12'd100));
    send_cmd(mk(sct_pkg::MODE_TICK, sct_pkg::REG_DUR_PHON, 8'h00, 12'd4095));
    send_cmd(mk(sct_pkg::MODE_READ, sct_pkg::REG_DUR_PHON, 8'h00, 12'd0));
    send_cmd(mk(sct_pkg::MODE_TICK, sct_pkg::REG_DUR_PHON, 8'h00, 12'd4095));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_INFL, 8'hff, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_DUR_PHON, 8'h3f, 12'd0));
    repeat (4) send_cmd(mk(sct_pkg::MODE_TICK, sct_pkg::REG_DUR_PHON, 8'h00, 12'd4095));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_CTRL_AMP, 8'hff, 12'd0));
    send_cmd(mk(sct_pkg::MODE_TICK, sct_pkg::REG_DUR_PHON, 8'h00, 12'd4095));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_FILTER, 8'haa, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, 3'd5, 8'h55, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, 3'd7, 8'hff, 12'd0));
    send_cmd(mk(MODE_UNUSED, sct_pkg::REG_RATE_INFL, 8'hff, 12'd4095));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_CTRL_AMP, 8'h7f, 12'd0));
    send_cmd(mk(sct_pkg::MODE_WRITE, sct_pkg::REG_RATE_INFL, 8'h00, 12'd0));

    for (int phase = 0; phase < 4; phase++) begin
      gaps_on  = phase[0];
      stall_on = phase[1] ^ phase[0];
      for (int n = 0; n < PhaseItems; n++) begin
        send_cmd(random_cmd());
      end
    end
    cmd_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sct_pkg.sv
hdl/sct_if.sv
hdl/speech_chip_register_timer.sv
verif/sct_timer_checker.sv
verif/tb_speech_chip_register_timer.sv
